>>> hw/rtl/sml_pkg.sv
// Shared types, codes and elaboration helpers for the sorted mutation table.
// Used by sml_cell, sml_or_tree and sorted_mutation_list; depends on nothing.
package sml_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int IDX_W      = 6;
  localparam int READ_SLOTS = 64;
  localparam int TREE_RADIX = 8;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_REMOVED   = 3'd2;
  localparam logic [2:0] STAT_ORDER_ERR = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_CLEARED   = 3'd5;
  localparam logic [2:0] STAT_READ_DONE = 3'd6;

  typedef struct packed {
    logic [1:0]       operation;
    logic [31:0]      position;
    logic [3:0]       parent_nuc;
    logic [3:0]       new_nuc;
    logic [IDX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  entry_count;
    logic [31:0] read_position;
    logic [3:0]  read_parent_nuc;
    logic [3:0]  read_new_nuc;
    logic        read_valid;
  } rsp_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [3:0]  par;
    logic [3:0]  nuc;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_UPDATE,
    ACT_REMOVE
  } cell_act_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [31:0]      key;
    logic [3:0]       par;
    logic [3:0]       nuc;
    logic [IDX_W-1:0] idx;
    cell_act_t        act;
  } cell_cmd_t;

  // Flags and read data that each cell hands to the OR tree.
  typedef struct packed {
    logic   upd;
    logic   rem;
    logic   err;
    logic   rd_valid;
    entry_t rd_ent;
  } leaf_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } fsm_state_t;

  function automatic int tree_nodes(input int n, input int lvl);
    int m;
    m = n;
    for (int k = 0; k < lvl; k++) begin
      m = (m + TREE_RADIX - 1) >> 3;
    end
    return m;
  endfunction

  function automatic int tree_levels(input int n);
    int l;
    int m;
    l = 1;
    m = (n + TREE_RADIX - 1) >> 3;
    while (m > 1) begin
      m = (m + TREE_RADIX - 1) >> 3;
      l++;
    end
    return l;
  endfunction

endpackage

>>> hw/rtl/sorted_mutation_list.sv
// Sorted mutation table: a row of compare-and-shift cells kept in position order.
// Top level; uses sml_pkg, sml_cell and sml_or_tree.
//
// A request enters on req when req_valid is high and req_stall is low; its
// single response leaves on rsp when rsp_valid is high and rsp_stall is low.
// Every cell compares its entry with the request at once; the per-cell hit
// and read flags are collected by a registered radix-8 OR tree of
// L = ceil(log8(TABLE_DEPTH)) levels (2 at the default depth of 64).
// A request is registered on acceptance, its flags pass through the L tree
// levels, and it then commits: all cells shift or update together and the
// response register is loaded.
// req_stall is high from acceptance until the commit.
// When rsp_stall holds a response, the next request is still accepted and
// evaluated; only its commit waits until the response register is free.
// Reset empties the table at once (the entry count goes to zero); entry
// contents need no clearing since only slots below the count are ever used.
module sorted_mutation_list #(
  parameter int TABLE_DEPTH = sml_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sml_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sml_pkg::rsp_t rsp
);
  import sml_pkg::*;

  localparam int               CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int               LEVELS  = tree_levels(TABLE_DEPTH);
  localparam int               LCNT_W  = $clog2(LEVELS + 1);
  localparam int               LEAF_W  = $bits(leaf_t);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [LCNT_W-1:0] EVAL_LAST = LCNT_W'(LEVELS - 1);

  fsm_state_t  state;
  fsm_state_t  state_next;
  logic [LCNT_W-1:0] eval_cnt;
  req_t        cmd;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+6:0] cnt_ext;
  cell_act_t   act;
  cell_cmd_t   cell_cmd;
  logic        accept;
  logic        out_free;
  logic        load;
  rsp_t        rsp_next;
  leaf_t       found;
  logic [LEAF_W-1:0] tree_root;
  logic [TABLE_DEPTH*LEAF_W-1:0] leaves;

  entry_t cell_ent [TABLE_DEPTH];
  logic   cell_lt  [TABLE_DEPTH];

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign found    = leaf_t'(tree_root);

  assign cell_cmd.key = cmd.position;
  assign cell_cmd.par = cmd.parent_nuc;
  assign cell_cmd.nuc = cmd.new_nuc;
  assign cell_cmd.idx = cmd.read_index;
  assign cell_cmd.act = act;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    logic   left_lt;
    entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_lt  = 1'b0;
    end else begin : g_body
      assign left_ent = cell_ent[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_ent = cell_ent[i];
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    sml_cell #(
      .IDX   (i),
      .DEPTH (TABLE_DEPTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .count     (count),
      .left_ent  (left_ent),
      .left_lt   (left_lt),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .lt        (cell_lt[i]),
      .leaf      (leaves[i*LEAF_W +: LEAF_W])
    );
  end

  sml_or_tree #(
    .N (TABLE_DEPTH),
    .W (LEAF_W)
  ) u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (tree_root)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (eval_cnt == EVAL_LAST) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the commit step: cell action, new count and the response.
  always_comb begin
    act        = ACT_NONE;
    load       = 1'b0;
    count_next = count;
    rsp_next   = '0;
    if (state == S_COMMIT && out_free) begin
      load = 1'b1;
      case (cmd.operation)
        OP_ADD: begin
          if (found.upd) begin
            act             = ACT_UPDATE;
            rsp_next.status = STAT_UPDATED;
          end else if (found.rem) begin
            act             = ACT_REMOVE;
            count_next      = count - 1'b1;
            rsp_next.status = STAT_REMOVED;
          end else if (found.err) begin
            rsp_next.status = STAT_ORDER_ERR;
          end else if (count == DEPTH_C) begin
            rsp_next.status = STAT_FULL;
          end else begin
            act             = ACT_INSERT;
            count_next      = count + 1'b1;
            rsp_next.status = STAT_INSERTED;
          end
        end
        OP_CLEAR: begin
          count_next      = '0;
          rsp_next.status = STAT_CLEARED;
        end
        OP_READ: begin
          rsp_next.status          = STAT_READ_DONE;
          rsp_next.read_position   = found.rd_ent.pos;
          rsp_next.read_parent_nuc = found.rd_ent.par;
          rsp_next.read_new_nuc    = found.rd_ent.nuc;
          rsp_next.read_valid      = found.rd_valid;
        end
        default: begin
          rsp_next.status = STAT_READ_DONE;
        end
      endcase
    end
    cnt_ext              = {7'd0, count_next};
    rsp_next.entry_count = cnt_ext[6:0];
  end

  assign req_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      eval_cnt  <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EVAL) begin
        eval_cnt <= eval_cnt + 1'b1;
      end else begin
        eval_cnt <= '0;
      end
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= req;
    end
    if (load) begin
      rsp <= rsp_next;
    end
  end

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count exceeds table depth");

  a_one_outcome : assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |-> $onehot0({found.upd, found.rem, found.err}))
    else $error("more than one cell claims the request position");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (load && act == ACT_INSERT) |=> count == CNT_W'($past(count) + 1'b1))
    else $error("insert did not grow the entry count");

  a_read_status : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.read_valid) |-> rsp.status == STAT_READ_DONE)
    else $error("read data flagged on a response that is not a read");

  a_rsp_from_commit : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_COMMIT)
    else $error("response raised outside the commit step");

endmodule

>>> hw/rtl/sml_cell.sv
// One slot of the sorted table: holds an entry, compares it with the request
// and shifts with its neighbors on insert or remove. Depends on sml_pkg.
module sml_cell #(
  parameter int IDX   = 0,
  parameter int DEPTH = sml_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  sml_pkg::cell_cmd_t         cmd,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  sml_pkg::entry_t            left_ent,
  input  logic                       left_lt,
  input  sml_pkg::entry_t            right_ent,
  output sml_pkg::entry_t            ent,
  output logic                       lt,
  output sml_pkg::leaf_t             leaf
);
  import sml_pkg::*;

  localparam int               CNT_W    = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);
  localparam bit               IS_HEAD  = (IDX == 0);
  localparam bit               READABLE = (IDX < READ_SLOTS);
  localparam logic [IDX_W-1:0] SLOT     = IDX_W'(IDX);

  entry_t ent_next;
  logic   occ;
  logic   first;
  logic   hit;
  logic   same_parent;
  logic   rd_hit;

  always_comb begin
    occ         = IDX_C < count;
    lt          = occ && (ent.pos < cmd.key);
    // The first slot not below the key is where the key lives or would go.
    first       = !lt && (IS_HEAD || left_lt);
    hit         = first && occ && (ent.pos == cmd.key);
    same_parent = ent.par == cmd.nuc;
    rd_hit      = READABLE && occ && (SLOT == cmd.idx);

    leaf.upd      = hit && !same_parent;
    leaf.rem      = hit && same_parent && (ent.nuc == cmd.par);
    leaf.err      = hit && same_parent && (ent.nuc != cmd.par);
    leaf.rd_valid = rd_hit;
    leaf.rd_ent   = rd_hit ? ent : '0;
  end

  always_comb begin
    ent_next = ent;
    case (cmd.act)
      ACT_INSERT: begin
        if (first) begin
          ent_next.pos = cmd.key;
          ent_next.par = cmd.par;
          ent_next.nuc = cmd.nuc;
        end else if (!lt) begin
          ent_next = left_ent;
        end
      end
      ACT_UPDATE: begin
        if (hit) begin
          ent_next.nuc = cmd.nuc;
        end
      end
      ACT_REMOVE: begin
        if (!lt) begin
          ent_next = right_ent;
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

>>> hw/rtl/sml_or_tree.sv
// Registered radix-8 OR tree that gathers the flags and read data of all cells.
// One register level per tree level. Depends on sml_pkg.
module sml_or_tree #(
  parameter int N = sml_pkg::DEPTH_DEF,
  parameter int W = $bits(sml_pkg::leaf_t)
) (
  input  logic           clk,
  input  logic [N*W-1:0] leaves,
  output logic [W-1:0]   root
);
  import sml_pkg::*;

  localparam int LEVELS = tree_levels(N);

  logic [LEVELS:1][N*W-1:0] lvl;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int NIN  = tree_nodes(N, l);
    localparam int NOUT = tree_nodes(N, l + 1);

    logic [N*W-1:0] src;
    logic [N*W-1:0] nxt;

    if (l == 0) begin : g_src_leaf
      assign src = leaves;
    end else begin : g_src_node
      assign src = lvl[l];
    end

    always_comb begin
      nxt = '0;
      for (int j = 0; j < NOUT; j++) begin
        for (int c = 0; c < TREE_RADIX; c++) begin
          if (j * TREE_RADIX + c < NIN) begin
            nxt[j*W +: W] = nxt[j*W +: W] | src[(j*TREE_RADIX + c)*W +: W];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      lvl[l+1] <= nxt;
    end
  end

  assign root = lvl[LEVELS][W-1:0];

endmodule
